// ===== design/vofp_pkg.sv =====
// Package for the valve opening from position unit.
// Shared types, register codes and constants; no dependencies.
package vofp_pkg;

  localparam int unsigned ENCODER_FULL_SCALE = 16383;

  localparam int unsigned POS_W      = 14;
  localparam int unsigned ANA_W      = 10;
  localparam int unsigned OPEN_W     = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned DIV_QW     = 16;
  localparam int unsigned DIVIDEND_W = 2 * DIV_QW;

  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ENCODER_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_DIRECTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_POINT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_POINT      = 2'd3;

  localparam logic              RST_ENCODER_MODE    = 1'b1;
  localparam logic [1:0]        RST_CLOSE_DIRECTION = 2'b11;
  localparam logic [POS_W-1:0]  RST_CLOSED_POINT    = 14'd255;
  localparam logic [POS_W-1:0]  RST_OPEN_POINT      = 14'd800;

  localparam logic [OPEN_W-1:0] Q16_ONE        = 17'h10000;
  localparam logic [OPEN_W-1:0] CURRENT_OFFSET = 17'd16384;

  // hundredths back to Q16: floor(h * 65536 / 100) = (h * HUND_RECIP) >> HUND_SHIFT
  localparam logic [6:0]  HUND_SCALE = 7'd100;
  localparam logic [27:0] HUND_RECIP = 28'd171798692;
  localparam int unsigned HUND_SHIFT = 18;

  typedef struct packed {
    logic [POS_W-1:0] encoder_position;
    logic [ANA_W-1:0] analog_position;
  } in_item_t;

  typedef struct packed {
    logic [OPEN_W-1:0] opening;
    logic [OPEN_W-1:0] output_current;
  } out_item_t;

  typedef struct packed {
    logic                  divide;
    logic                  hund;
    logic [OPEN_W-1:0]     fixed;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIV_QW-1:0]     den;
  } div_req_t;

  function automatic logic [OPEN_W-1:0] hund_to_q16(input logic [6:0] h);
    logic [34:0] prod;
    prod = 35'(h) * 35'(HUND_RECIP);
    return prod[HUND_SHIFT +: OPEN_W];
  endfunction

endpackage

// ===== design/vofp_fifo.sv =====
// Small register queue used between front and back and at the result side.
// Depends on nothing; width and depth come from the instantiating module.
module vofp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== design/vofp_front.sv =====
// Front end: configuration registers, wrap flag and classification of each request.
// Depends on vofp_pkg.
module vofp_front #(
  parameter int unsigned FullScale = vofp_pkg::ENCODER_FULL_SCALE
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vofp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [vofp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                accept_i,
  input  vofp_pkg::in_item_t                  item_i,
  output vofp_pkg::div_req_t                  req_o
);

  localparam logic signed [17:0] FsS = 18'(FullScale);

  logic                            enc_mode_q;
  logic [1:0]                      close_dir_q;
  logic [vofp_pkg::POS_W-1:0]      closed_q, open_q;
  logic                            wrap_q, wrap_d;

  logic [vofp_pkg::POS_W-1:0]      x, x1, x2, ad1, ad2, dnum, dden;
  logic signed [17:0]              xs, x1s, x2s, wnum, wden;
  logic                            lt12, gt12, eq12, dpos, dneg;
  logic                            direct, clamp0, clamp1, wdead;
  logic [vofp_pkg::DIV_QW-1:0]     div_num;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_mode_q  <= vofp_pkg::RST_ENCODER_MODE;
      close_dir_q <= vofp_pkg::RST_CLOSE_DIRECTION;
      closed_q    <= vofp_pkg::RST_CLOSED_POINT;
      open_q      <= vofp_pkg::RST_OPEN_POINT;
      wrap_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          vofp_pkg::REG_ENCODER_MODE:    enc_mode_q  <= cfg_data_i[0];
          vofp_pkg::REG_CLOSE_DIRECTION: close_dir_q <= cfg_data_i[1:0];
          vofp_pkg::REG_CLOSED_POINT:    closed_q    <= cfg_data_i;
          vofp_pkg::REG_OPEN_POINT:      open_q      <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        wrap_q <= wrap_d;
      end
    end
  end

  assign x1   = closed_q;
  assign x2   = open_q;
  assign x    = enc_mode_q ? item_i.encoder_position
                           : {{(vofp_pkg::POS_W-vofp_pkg::ANA_W){1'b0}}, item_i.analog_position};
  assign lt12 = x1 < x2;
  assign gt12 = x1 > x2;
  assign eq12 = x1 == x2;
  assign dneg = close_dir_q[1];
  assign dpos = (close_dir_q == 2'b01);

  always_comb begin
    priority if ((gt12 && dpos) || (lt12 && dneg)) begin
      wrap_d = 1'b1;
    end else if ((gt12 && dneg) || (lt12 && dpos)) begin
      wrap_d = 1'b0;
    end else begin
      wrap_d = wrap_q;
    end
  end

  assign direct = !enc_mode_q || wrap_d;

  // direct span
  assign clamp0 = eq12 || (lt12 ? (x <= x1) : (x >= x1));
  assign clamp1 = lt12 ? (x >= x2) : (x <= x2);
  assign dnum   = lt12 ? (x - x1) : (x1 - x);
  assign dden   = lt12 ? (x2 - x1) : (x1 - x2);

  // wrap span
  assign xs   = $signed({4'b0, x});
  assign x1s  = $signed({4'b0, x1});
  assign x2s  = $signed({4'b0, x2});
  assign wden = lt12 ? FsS - (x2s - x1s) : FsS - (x1s - x2s);
  assign ad1  = (x >= x1) ? (x - x1) : (x1 - x);
  assign ad2  = (x >= x2) ? (x - x2) : (x2 - x);

  always_comb begin
    wnum  = '0;
    wdead = 1'b0;
    if (lt12) begin
      if (x < x1) begin
        wnum = x1s - xs;
      end else if (x > x2) begin
        wnum = FsS - (xs - x1s);
      end else begin
        wdead = 1'b1;
      end
    end else begin
      if (x < x2) begin
        wnum = FsS - (x1s - xs);
      end else if (x > x1) begin
        wnum = xs - x1s;
      end else begin
        wdead = 1'b1;
      end
    end
  end

  always_comb begin
    req_o        = '0;
    div_num      = '0;
    req_o.hund   = !enc_mode_q;
    if (direct) begin
      priority if (clamp0) begin
        req_o.fixed = '0;
      end else if (clamp1) begin
        req_o.fixed = vofp_pkg::Q16_ONE;
      end else begin
        req_o.divide = 1'b1;
        div_num      = vofp_pkg::DIV_QW'(dnum);
        req_o.den    = vofp_pkg::DIV_QW'(dden);
      end
    end else begin
      priority if (wdead) begin
        req_o.fixed = (ad1 < ad2) ? '0 : vofp_pkg::Q16_ONE;
      end else if (wnum <= 0) begin
        req_o.fixed = '0;
      end else if (wden <= 0 || wnum >= wden) begin
        req_o.fixed = vofp_pkg::Q16_ONE;
      end else begin
        req_o.divide = 1'b1;
        div_num      = wnum[vofp_pkg::DIV_QW-1:0];
        req_o.den    = wden[vofp_pkg::DIV_QW-1:0];
      end
    end
    req_o.dividend = req_o.hund
      ? vofp_pkg::DIVIDEND_W'(vofp_pkg::DIVIDEND_W'(div_num) *
                              vofp_pkg::DIVIDEND_W'(vofp_pkg::HUND_SCALE))
      : {div_num, {vofp_pkg::DIV_QW{1'b0}}};
  end

endmodule

// ===== design/vofp_back.sv =====
// Back end: pipelined restoring divider, one quotient bit per stage, then scaling.
// Depends on vofp_pkg.
module vofp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vofp_pkg::div_req_t   req_i,
  input  logic                 req_valid_i,
  output logic                 req_pop_o,
  output vofp_pkg::out_item_t  res_o,
  output logic                 res_push_o,
  input  logic                 res_full_i
);

  localparam int unsigned NS = vofp_pkg::DIV_QW;
  localparam int unsigned QW = vofp_pkg::DIV_QW;

  logic                          valid_q  [NS+1];
  logic                          divide_q [NS+1];
  logic                          hund_q   [NS+1];
  logic [vofp_pkg::OPEN_W-1:0]   fixed_q  [NS+1];
  logic [QW-1:0]                 rem_q    [NS+1];
  logic [QW-1:0]                 low_q    [NS+1];
  logic [QW-1:0]                 den_q    [NS+1];
  logic [QW-1:0]                 quo_q    [NS+1];

  logic [QW:0]                   trial   [NS];
  logic                          ge      [NS];
  logic                          adv;
  logic [vofp_pkg::OPEN_W-1:0]   opening;

  assign adv        = !(valid_q[NS] && res_full_i);
  assign req_pop_o  = adv && req_valid_i;
  assign res_push_o = adv && valid_q[NS];

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      trial[k] = {rem_q[k], low_q[k][QW-1]};
      ge[k]    = trial[k] >= {1'b0, den_q[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else if (adv) begin
      valid_q[0] <= req_valid_i;
      for (int k = 0; k < NS; k++) begin
        valid_q[k+1] <= valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      divide_q[0] <= req_i.divide;
      hund_q[0]   <= req_i.hund;
      fixed_q[0]  <= req_i.fixed;
      rem_q[0]    <= req_i.dividend[vofp_pkg::DIVIDEND_W-1 -: QW];
      low_q[0]    <= req_i.dividend[QW-1:0];
      den_q[0]    <= req_i.den;
      quo_q[0]    <= '0;
      for (int k = 0; k < NS; k++) begin
        divide_q[k+1] <= divide_q[k];
        hund_q[k+1]   <= hund_q[k];
        fixed_q[k+1]  <= fixed_q[k];
        den_q[k+1]    <= den_q[k];
        low_q[k+1]    <= {low_q[k][QW-2:0], 1'b0};
        quo_q[k+1]    <= {quo_q[k][QW-2:0], ge[k]};
        rem_q[k+1]    <= ge[k] ? QW'(trial[k] - {1'b0, den_q[k]}) : trial[k][QW-1:0];
      end
    end
  end

  always_comb begin
    priority if (!divide_q[NS]) begin
      opening = fixed_q[NS];
    end else if (hund_q[NS]) begin
      opening = vofp_pkg::hund_to_q16(quo_q[NS][6:0]);
    end else begin
      opening = {1'b0, quo_q[NS]};
    end
    res_o.opening        = opening;
    res_o.output_current = opening + vofp_pkg::CURRENT_OFFSET;
  end

endmodule

// ===== design/valve_opening_from_position_unit.sv =====
// Top level of the valve opening from position unit.
// Depends on vofp_pkg, vofp_front, vofp_fifo and vofp_back.
//
// Takes one position request per cycle while full is low and returns the valve
// opening as an unsigned Q16 fraction together with the 4-20 mA loop current
// (opening+16384, in 1/4096 mA). Sustained rate is one request per clock as long
// as results are popped; a full result queue stalls the divider. A request passes
// through the middle queue, the divider pipeline that resolves one quotient bit
// per stage, and then the result queue. The front end classifies each request
// (clamp, dead zone or ratio) and updates the wrap flag; a 2-entry queue
// decouples it from the divider, and a 2-entry queue holds results until popped.
// The user must write configuration only while the unit is idle; the block
// itself does not enforce this.
module valve_opening_from_position_unit #(
  parameter int unsigned ENCODER_FULL_SCALE = vofp_pkg::ENCODER_FULL_SCALE,
  parameter int unsigned MID_DEPTH          = vofp_pkg::MID_DEPTH,
  parameter int unsigned OUT_DEPTH          = vofp_pkg::OUT_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vofp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vofp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  vofp_pkg::in_item_t               req_i,
  input  logic                             pop,
  output logic                             empty,
  output vofp_pkg::out_item_t              res_o
);

  localparam int unsigned ReqW = $bits(vofp_pkg::div_req_t);
  localparam int unsigned ResW = $bits(vofp_pkg::out_item_t);

  logic                 accept;
  vofp_pkg::div_req_t   front_req, mid_req;
  logic                 mid_full, mid_empty, mid_pop;
  vofp_pkg::out_item_t  back_res;
  logic                 res_push, res_full;

  assign full   = mid_full;
  assign accept = push && !mid_full;

  vofp_front #(
    .FullScale (ENCODER_FULL_SCALE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (req_i),
    .req_o      (front_req)
  );

  vofp_fifo #(
    .Width (ReqW),
    .Depth (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_req),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_req),
    .empty_o (mid_empty)
  );

  vofp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mid_req),
    .req_valid_i (!mid_empty),
    .req_pop_o   (mid_pop),
    .res_o       (back_res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  vofp_fifo #(
    .Width (ResW),
    .Depth (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_o),
    .empty_o (empty)
  );

  a_open_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> res_o.opening <= vofp_pkg::Q16_ONE)
    else $error("opening beyond full scale");

  a_current_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> res_o.output_current == res_o.opening + vofp_pkg::CURRENT_OFFSET)
    else $error("loop current does not match opening");

  a_mid_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !mid_empty)
    else $error("accepted request missing from middle queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

endmodule

// ===== tb/valve_opening_from_position_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for valve_opening_from_position_unit.
// Predicts each opening and loop current from the calibration in use and checks
// them in order; depends on vofp_pkg and the unit itself.
module valve_opening_from_position_unit_test;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [vofp_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [vofp_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            push;
  logic                            full;
  vofp_pkg::in_item_t              req_i;
  logic                            pop;
  logic                            empty;
  vofp_pkg::out_item_t             res_o;

  // calibration as the unit should hold it, plus the held wrap flag
  logic                       cal_encoder_mode;
  logic [1:0]                 cal_close_dir;
  logic [vofp_pkg::POS_W-1:0] cal_closed;
  logic [vofp_pkg::POS_W-1:0] cal_open;
  logic                       travel_direct;

  vofp_pkg::out_item_t pending_results[$];
  vofp_pkg::out_item_t want;
  int unsigned         mismatches;
  bit                  steady;
  int unsigned         gap_odds;

  valve_opening_from_position_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .req_i      (req_i),
    .pop        (pop),
    .empty      (empty),
    .res_o      (res_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [vofp_pkg::OPEN_W-1:0] clamped_span(longint x1, longint x2,
                                                               longint x, bit hundredths);
    longint num;
    longint den;
    longint h;
    if ((x1 - x) * (x1 - x2) <= 0) return '0;
    if ((x2 - x) * (x2 - x1) <= 0) return vofp_pkg::Q16_ONE;
    num = (x > x1) ? x - x1 : x1 - x;
    den = (x2 > x1) ? x2 - x1 : x1 - x2;
    if (!hundredths) return vofp_pkg::OPEN_W'((num << 16) / den);
    h = (num * 100) / den;
    return vofp_pkg::OPEN_W'((h * 65536) / 100);
  endfunction

  function automatic logic [vofp_pkg::OPEN_W-1:0] arc_ratio(longint num, longint den);
    if (num <= 0) return '0;
    if (den <= 0 || num >= den) return vofp_pkg::Q16_ONE;
    return vofp_pkg::OPEN_W'((num << 16) / den);
  endfunction

  function automatic logic [vofp_pkg::OPEN_W-1:0] wrapped_span(longint x1, longint x2,
                                                               longint x);
    longint fs;
    longint d1;
    longint d2;
    fs = longint'(vofp_pkg::ENCODER_FULL_SCALE);
    if (x1 < x2) begin
      if (x < x1) return arc_ratio(x1 - x, fs - (x2 - x1));
      if (x > x2) return arc_ratio(fs - (x - x1), fs - (x2 - x1));
    end else begin
      if (x < x2) return arc_ratio(fs - (x1 - x), fs - (x1 - x2));
      if (x > x1) return arc_ratio(x - x1, fs - (x1 - x2));
    end
    // dead zone snaps to the nearer end
    d1 = (x > x1) ? x - x1 : x1 - x;
    d2 = (x > x2) ? x - x2 : x2 - x;
    return (d1 < d2) ? '0 : vofp_pkg::Q16_ONE;
  endfunction

  function automatic vofp_pkg::out_item_t predict_opening(vofp_pkg::in_item_t item);
    longint                      x1;
    longint                      x2;
    int                          dir_sign;
    int                          prod_sign;
    logic [vofp_pkg::OPEN_W-1:0] opening;
    vofp_pkg::out_item_t         res;
    x1 = longint'(cal_closed);
    x2 = longint'(cal_open);
    dir_sign = (cal_close_dir == 2'b00) ? 0 : (cal_close_dir[1] ? -1 : 1);
    prod_sign = ((x1 > x2) ? 1 : ((x1 < x2) ? -1 : 0)) * dir_sign;
    if (prod_sign > 0) travel_direct = 1'b1;
    else if (prod_sign < 0) travel_direct = 1'b0;
    if (cal_encoder_mode) begin
      if (travel_direct) begin
        opening = clamped_span(x1, x2, longint'(item.encoder_position), 1'b0);
      end else begin
        opening = wrapped_span(x1, x2, longint'(item.encoder_position));
      end
    end else begin
      opening = clamped_span(x1, x2, longint'(item.analog_position), 1'b1);
    end
    res.opening        = opening;
    res.output_current = opening + vofp_pkg::CURRENT_OFFSET;
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result opening %0d current %0d", $time,
                 res_o.opening, res_o.output_current);
      end else begin
        want = pending_results.pop_front();
        if (res_o.opening !== want.opening) begin
          mismatches++;
          $display("%0t: opening expected %0d actual %0d", $time,
                   want.opening, res_o.opening);
        end
        if (res_o.output_current !== want.output_current) begin
          mismatches++;
          $display("%0t: output_current expected %0d actual %0d", $time,
                   want.output_current, res_o.output_current);
        end
      end
    end
  end

  // receiver: pops in bursts with random stalls
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (steady || $urandom_range(0, 3) != 0) begin
        pop = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end else begin
        pop = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
    end
  end

  task automatic send_item(vofp_pkg::in_item_t item);
    if (!steady && gap_odds != 0 && $urandom_range(0, 3 * gap_odds) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    req_i = item;
    push  = 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_results.push_back(predict_opening(item));
    @(negedge clk_i);
  endtask

  task automatic send_encoder(logic [vofp_pkg::POS_W-1:0] pos);
    vofp_pkg::in_item_t item;
    item.encoder_position = pos;
    item.analog_position  = vofp_pkg::ANA_W'($urandom);
    send_item(item);
  endtask

  task automatic send_analog(logic [vofp_pkg::ANA_W-1:0] pos);
    vofp_pkg::in_item_t item;
    item.encoder_position = vofp_pkg::POS_W'($urandom);
    item.analog_position  = pos;
    send_item(item);
  endtask

  task automatic wait_for_results;
    push = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [vofp_pkg::CFG_IDX_W-1:0] idx,
                           logic [vofp_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic set_calibration(logic mode, logic [1:0] dir,
                                 logic [vofp_pkg::POS_W-1:0] closed,
                                 logic [vofp_pkg::POS_W-1:0] open);
    wait_for_results();
    write_reg(vofp_pkg::REG_ENCODER_MODE, vofp_pkg::CFG_DATA_W'(mode));
    write_reg(vofp_pkg::REG_CLOSE_DIRECTION, vofp_pkg::CFG_DATA_W'(dir));
    write_reg(vofp_pkg::REG_CLOSED_POINT, closed);
    write_reg(vofp_pkg::REG_OPEN_POINT, open);
    cal_encoder_mode = mode;
    cal_close_dir    = dir;
    cal_closed       = closed;
    cal_open         = open;
  endtask

  task automatic test_direct_path;
    // reset calibration: closed below open, closing negative, so direct travel
    send_encoder(14'd0);
    send_encoder(14'd255);
    send_encoder(14'd527);
    send_encoder(14'd800);
    send_encoder(14'd16383);
  endtask

  task automatic test_wrap_path;
    set_calibration(1'b1, 2'b01, 14'd255, 14'd800);
    send_encoder(14'd0);
    send_encoder(14'd254);
    send_encoder(14'd400);
    send_encoder(14'd700);
    send_encoder(14'd801);
    send_encoder(14'd16383);
    set_calibration(1'b1, 2'b11, 14'd12000, 14'd3000);
    send_encoder(14'd2999);
    send_encoder(14'd7000);
    send_encoder(14'd12001);
  endtask

  task automatic test_special_cases;
    // zero direction holds the wrap flag; equal points in the dead zone open fully
    set_calibration(1'b1, 2'b00, 14'd5000, 14'd5000);
    send_encoder(14'd5000);
    send_encoder(14'd4999);
    // arc of one count saturates
    set_calibration(1'b1, 2'b01, 14'd1, 14'd16383);
    send_encoder(14'd0);
    // pattern -2 counts as negative; empty arc gives zero
    set_calibration(1'b1, 2'b10, 14'd16383, 14'd5);
    send_encoder(14'd0);
    // direct travel with equal points clamps closed
    set_calibration(1'b1, 2'b01, 14'd9000, 14'd100);
    send_encoder(14'd9000);
    set_calibration(1'b1, 2'b00, 14'd100, 14'd100);
    send_encoder(14'd100);
  endtask

  task automatic test_analog_mode;
    set_calibration(1'b0, 2'b11, 14'd100, 14'd900);
    send_analog(10'd0);
    send_analog(10'd100);
    send_analog(10'd347);
    send_analog(10'd900);
    send_analog(10'd1023);
    set_calibration(1'b0, 2'b01, 14'd1023, 14'd0);
    send_analog(10'd512);
  endtask

  function automatic logic [vofp_pkg::POS_W-1:0] pick_point(bit analog,
                                                            logic [vofp_pkg::POS_W-1:0] other);
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return 14'd16383;
      2:       return other;
      3:       return other + vofp_pkg::POS_W'($urandom_range(0, 40)) - 14'd20;
      4:       return vofp_pkg::POS_W'($urandom_range(0, 1023));
      default: return analog ? vofp_pkg::POS_W'($urandom_range(0, 1100))
                             : vofp_pkg::POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [vofp_pkg::POS_W-1:0] pick_position(
      logic [vofp_pkg::POS_W-1:0] top);
    case ($urandom_range(0, 5))
      0, 1:    return vofp_pkg::POS_W'($urandom) & top;
      2:       return (cal_closed + vofp_pkg::POS_W'($urandom_range(0, 8)) - 14'd4) & top;
      3:       return (cal_open + vofp_pkg::POS_W'($urandom_range(0, 8)) - 14'd4) & top;
      4:       return $urandom_range(0, 1) ? top : '0;
      default: return vofp_pkg::POS_W'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic test_random_traffic;
    int unsigned                left;
    int unsigned                n;
    logic                       mode;
    logic [vofp_pkg::POS_W-1:0] closed;
    left = 1520;
    while (left > 0) begin
      if (left <= 150) steady = 1'b1;
      mode   = ($urandom_range(0, 3) != 0);
      closed = pick_point(!mode, cal_open);
      set_calibration(mode, 2'($urandom), closed, pick_point(!mode, closed));
      if (steady) begin
        n = left;
      end else begin
        n = $urandom_range(30, 120);
        if (left - n < 150) n = left - 150;
      end
      gap_odds = steady ? 0 : $urandom_range(0, 4);
      repeat (n) begin
        if (cal_encoder_mode) send_encoder(pick_position(14'h3FFF));
        else send_analog(vofp_pkg::ANA_W'(pick_position(14'h03FF)));
      end
      left -= n;
    end
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    push             = 1'b0;
    req_i            = '0;
    mismatches       = 0;
    steady           = 1'b0;
    gap_odds         = 2;
    cal_encoder_mode = vofp_pkg::RST_ENCODER_MODE;
    cal_close_dir    = vofp_pkg::RST_CLOSE_DIRECTION;
    cal_closed       = vofp_pkg::RST_CLOSED_POINT;
    cal_open         = vofp_pkg::RST_OPEN_POINT;
    travel_direct    = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_direct_path();
    test_wrap_path();
    test_special_cases();
    test_analog_mode();
    test_random_traffic();
    wait_for_results();
    repeat (40) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/vofp_pkg.sv
design/vofp_fifo.sv
design/vofp_front.sv
design/vofp_back.sv
design/valve_opening_from_position_unit.sv
tb/valve_opening_from_position_unit_test.sv
